>>> rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define CIDH_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cidh assertion failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define CIDH_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cidh assertion failed");

`endif

>>> rtl/cidh_pkg.sv
// ----------------------------------------------------------------------------
// cidh_pkg
// Types, constants and helper functions for the flow community ID hash.
// ----------------------------------------------------------------------------
package cidh_pkg;

  typedef logic [15:0][31:0] word16_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    logic [31:0] e;
    word16_t     w;
  } sha_st_t;

  typedef struct packed {
    logic    valid;
    sha_st_t st;
  } cell_bus_t;

  localparam logic [31:0] H0 = 32'h67452301;
  localparam logic [31:0] H1 = 32'hEFCDAB89;
  localparam logic [31:0] H2 = 32'h98BADCFE;
  localparam logic [31:0] H3 = 32'h10325476;
  localparam logic [31:0] H4 = 32'hC3D2E1F0;

  localparam int unsigned NumRounds = 80;
  localparam logic [15:0] IdPrefix = 16'h313A;
  localparam logic [7:0]  PadChar  = 8'h3D;

  function automatic logic [31:0] round_f(input logic [6:0] rnd, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    if (rnd < 7'd20) begin
      f = (b & c) | (~b & d);
    end else if (rnd < 7'd40) begin
      f = b ^ c ^ d;
    end else if (rnd < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
    end else begin
      f = b ^ c ^ d;
    end
    return f;
  endfunction

  function automatic logic [31:0] round_k(input logic [6:0] rnd);
    logic [31:0] k;
    if (rnd < 7'd20) begin
      k = 32'h5A827999;
    end else if (rnd < 7'd40) begin
      k = 32'h6ED9EBA1;
    end else if (rnd < 7'd60) begin
      k = 32'h8F1BBCDC;
    end else begin
      k = 32'hCA62C1D6;
    end
    return k;
  endfunction

  function automatic logic [7:0] b64_char(input logic [5:0] v);
    logic [7:0] ch;
    if (v < 6'd26) begin
      ch = 8'h41 + {2'b00, v};
    end else if (v < 6'd52) begin
      ch = 8'h61 + {2'b00, v - 6'd26};
    end else if (v < 6'd62) begin
      ch = 8'h30 + {2'b00, v - 6'd52};
    end else if (v == 6'd62) begin
      ch = 8'h2B;
    end else begin
      ch = 8'h2F;
    end
    return ch;
  endfunction

endpackage

>>> rtl/cidh_prep.sv
// ----------------------------------------------------------------------------
// cidh_prep
// Orders the flow endpoints and builds the padded SHA-1 block.
// ----------------------------------------------------------------------------
module cidh_prep (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  logic [15:0]        seed,
  input  logic               is_ipv6,
  input  logic [63:0]        src_addr_hi,
  input  logic [63:0]        src_addr_lo,
  input  logic [63:0]        dst_addr_hi,
  input  logic [63:0]        dst_addr_lo,
  input  logic [15:0]        src_port,
  input  logic [15:0]        dst_port,
  input  logic [7:0]         proto_num,
  output cidh_pkg::cell_bus_t bus_out
);
  import cidh_pkg::*;

  logic [127:0] sa;
  logic [127:0] da;
  logic         lt;
  logic         eq;
  logic         src_first;
  logic [127:0] fa;
  logic [127:0] sa2;
  logic [15:0]  fp;
  logic [15:0]  sp2;
  logic [511:0] blk;
  cell_bus_t    bus_r;
  cell_bus_t    bus_nxt;

  always_comb begin
    sa  = is_ipv6 ? {src_addr_hi, src_addr_lo} : {96'd0, src_addr_lo[31:0]};
    da  = is_ipv6 ? {dst_addr_hi, dst_addr_lo} : {96'd0, dst_addr_lo[31:0]};
    lt  = sa < da;
    eq  = sa == da;
    src_first = lt || (eq && (src_port < dst_port));
    fa  = src_first ? sa : da;
    sa2 = src_first ? da : sa;
    fp  = src_first ? src_port : dst_port;
    sp2 = src_first ? dst_port : src_port;
    if (is_ipv6) begin
      blk = {seed, fa, sa2, proto_num, 8'h00, fp, sp2, 8'h80, 120'd0, 64'd320};
    end else begin
      blk = {seed, fa[31:0], sa2[31:0], proto_num, 8'h00, fp, sp2, 8'h80, 312'd0,
             64'd128};
    end
    bus_nxt.valid = accept;
    bus_nxt.st.a  = H0;
    bus_nxt.st.b  = H1;
    bus_nxt.st.c  = H2;
    bus_nxt.st.d  = H3;
    bus_nxt.st.e  = H4;
    for (int j = 0; j < 16; j++) begin
      bus_nxt.st.w[j] = blk[511 - 32*j -: 32];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bus_r.valid <= 1'b0;
    end else begin
      bus_r.valid <= bus_nxt.valid;
    end
    bus_r.st <= bus_nxt.st;
  end

  assign bus_out = bus_r;

endmodule

>>> rtl/cidh_cell.sv
// ----------------------------------------------------------------------------
// cidh_cell
// One SHA-1 round with its sliding message schedule window.
// ----------------------------------------------------------------------------
module cidh_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [6:0]          round_idx,
  input  cidh_pkg::cell_bus_t bus_in,
  output cidh_pkg::cell_bus_t bus_out
);
  import cidh_pkg::*;

  logic [31:0] t;
  logic [31:0] wn;
  cell_bus_t   bus_r;
  cell_bus_t   bus_nxt;

  always_comb begin
    t = {bus_in.st.a[26:0], bus_in.st.a[31:27]}
        + round_f(round_idx, bus_in.st.b, bus_in.st.c, bus_in.st.d)
        + bus_in.st.e + round_k(round_idx) + bus_in.st.w[0];
    wn = bus_in.st.w[13] ^ bus_in.st.w[8] ^ bus_in.st.w[2] ^ bus_in.st.w[0];
    bus_nxt.valid = bus_in.valid;
    bus_nxt.st.a  = t;
    bus_nxt.st.b  = bus_in.st.a;
    bus_nxt.st.c  = {bus_in.st.b[1:0], bus_in.st.b[31:2]};
    bus_nxt.st.d  = bus_in.st.c;
    bus_nxt.st.e  = bus_in.st.d;
    for (int j = 0; j < 15; j++) begin
      bus_nxt.st.w[j] = bus_in.st.w[j + 1];
    end
    bus_nxt.st.w[15] = {wn[30:0], wn[31]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bus_r.valid <= 1'b0;
    end else begin
      bus_r.valid <= bus_nxt.valid;
    end
    bus_r.st <= bus_nxt.st;
  end

  assign bus_out = bus_r;

endmodule

>>> rtl/cidh_out.sv
// ----------------------------------------------------------------------------
// cidh_out
// Final digest addition, Base64 text and four-word serializer.
// ----------------------------------------------------------------------------
module cidh_out (
  input  logic                clk,
  input  logic                rst_n,
  input  cidh_pkg::cell_bus_t bus_in,
  output logic                strobe,
  output logic [63:0]         text_chunk,
  output logic [3:0]          chunk_bytes,
  output logic                last
);
  import cidh_pkg::*;

  logic         dig_v_r;
  logic [159:0] digest_r;
  logic [161:0] ext;
  logic [239:0] text;
  logic [239:0] text_r;
  logic [2:0]   cnt_r;
  logic         strobe_r;
  logic [63:0]  chunk_r;
  logic [3:0]   bytes_r;
  logic         last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dig_v_r <= 1'b0;
    end else begin
      dig_v_r <= bus_in.valid;
    end
    digest_r <= {H0 + bus_in.st.a, H1 + bus_in.st.b, H2 + bus_in.st.c,
                 H3 + bus_in.st.d, H4 + bus_in.st.e};
  end

  always_comb begin
    ext = {digest_r, 2'b00};
    text[239:224] = IdPrefix;
    for (int j = 0; j < 27; j++) begin
      text[223 - 8*j -: 8] = b64_char(ext[161 - 6*j -: 6]);
    end
    text[7:0] = PadChar;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= 3'd0;
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= cnt_r != 3'd0;
      if (dig_v_r) begin
        cnt_r <= 3'd4;
      end else if (cnt_r != 3'd0) begin
        cnt_r <= cnt_r - 3'd1;
      end
    end
    if (dig_v_r) begin
      text_r <= text;
    end else if (cnt_r != 3'd0) begin
      text_r <= {text_r[175:0], 64'd0};
    end
    chunk_r <= text_r[239:176];
    bytes_r <= (cnt_r == 3'd1) ? 4'd6 : 4'd8;
    last_r  <= cnt_r == 3'd1;
  end

  assign strobe      = strobe_r;
  assign text_chunk  = chunk_r;
  assign chunk_bytes = bytes_r;
  assign last        = last_r;

endmodule

>>> rtl/flow_community_id_hash.sv
// ----------------------------------------------------------------------------
// flow_community_id_hash
// Community ID v1 flow hash: one flow tuple in, four text words out.
// ----------------------------------------------------------------------------
// A tuple is taken when start is high and busy is low; busy then stays high
// while the gap counter runs down, and no new tuple is taken meanwhile. The
// tuple passes a preparation register and a chain of 80 SHA-1 round cells,
// one round per cycle, then a digest register and the serializer registers;
// the four words of the identifier leave one per cycle. Words cannot be held
// off: out_strobe marks each one for a single cycle.
module flow_community_id_hash (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_community_seed,
  input  logic        start,
  output logic        busy,
  input  logic        in_is_ipv6,
  input  logic [63:0] in_src_addr_hi,
  input  logic [63:0] in_src_addr_lo,
  input  logic [63:0] in_dst_addr_hi,
  input  logic [63:0] in_dst_addr_lo,
  input  logic [15:0] in_src_port,
  input  logic [15:0] in_dst_port,
  input  logic [7:0]  in_proto_num,
  output logic        out_strobe,
  output logic [63:0] out_text_chunk,
  output logic [3:0]  out_chunk_bytes,
  output logic        out_last
);
  import cidh_pkg::*;

  logic [15:0] seed_r;
  logic [1:0]  gap_r;
  logic        accept;
  cell_bus_t   chain [NumRounds + 1];

  assign accept = start && !busy;
  assign busy   = gap_r != 2'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= 16'd0;
      gap_r  <= 2'd0;
    end else begin
      if (cfg_we) begin
        seed_r <= cfg_community_seed;
      end
      if (accept) begin
        gap_r <= 2'd3;
      end else if (gap_r != 2'd0) begin
        gap_r <= gap_r - 2'd1;
      end
    end
  end

  cidh_prep u_prep (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .seed        (seed_r),
    .is_ipv6     (in_is_ipv6),
    .src_addr_hi (in_src_addr_hi),
    .src_addr_lo (in_src_addr_lo),
    .dst_addr_hi (in_dst_addr_hi),
    .dst_addr_lo (in_dst_addr_lo),
    .src_port    (in_src_port),
    .dst_port    (in_dst_port),
    .proto_num   (in_proto_num),
    .bus_out     (chain[0])
  );

  for (genvar g = 0; g < NumRounds; g++) begin : g_round
    cidh_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .round_idx (7'(g)),
      .bus_in    (chain[g]),
      .bus_out   (chain[g + 1])
    );
  end

  cidh_out u_out (
    .clk         (clk),
    .rst_n       (rst_n),
    .bus_in      (chain[NumRounds]),
    .strobe      (out_strobe),
    .text_chunk  (out_text_chunk),
    .chunk_bytes (out_chunk_bytes),
    .last        (out_last)
  );

endmodule

>>> rtl/cidh_checker.sv
// ----------------------------------------------------------------------------
// cidh_checker
// Port-level checks on the flow community ID hash, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cidh_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_strobe,
  input logic [3:0]  out_chunk_bytes,
  input logic        out_last
);

  `CIDH_ASSERT_NEXT(a_busy_after_take, start && !busy, busy)
  `CIDH_ASSERT_NOW(a_last_short, out_strobe && out_last, out_chunk_bytes == 4'd6)
  `CIDH_ASSERT_NOW(a_mid_full, out_strobe && !out_last, out_chunk_bytes == 4'd8)
  `CIDH_ASSERT_NOW(a_last_after_three, out_strobe && out_last, $past(out_strobe, 3))

endmodule

bind flow_community_id_hash cidh_checker u_cidh_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_strobe      (out_strobe),
  .out_chunk_bytes (out_chunk_bytes),
  .out_last        (out_last)
);

>>> bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the flow community ID hash. Flow tuples are driven
// through the start/busy port. A local SHA-1 and Base64 predictor computes
// the four identifier words, and each word is checked against the oldest one
// waiting in line.
// ----------------------------------------------------------------------------
module testbench;

  typedef struct {
    logic        v6;
    logic [63:0] sa_hi;
    logic [63:0] sa_lo;
    logic [63:0] da_hi;
    logic [63:0] da_lo;
    logic [15:0] sp;
    logic [15:0] dp;
    logic [7:0]  proto;
  } flow_t;

  typedef struct {
    logic [63:0] chunk;
    logic [3:0]  nbytes;
    logic        last;
  } word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_community_seed = '0;
  logic        start = 1'b0;
  logic        busy;
  logic        busy_q;
  logic        in_is_ipv6 = 1'b0;
  logic [63:0] in_src_addr_hi = '0;
  logic [63:0] in_src_addr_lo = '0;
  logic [63:0] in_dst_addr_hi = '0;
  logic [63:0] in_dst_addr_lo = '0;
  logic [15:0] in_src_port = '0;
  logic [15:0] in_dst_port = '0;
  logic [7:0]  in_proto_num = '0;
  logic        out_strobe;
  logic [63:0] out_text_chunk;
  logic [3:0]  out_chunk_bytes;
  logic        out_last;

  flow_t       pending_flows[$];
  word_t       expected_words[$];
  logic [15:0] seed_model = '0;
  int          gap_pct = 0;
  int          error_count = 0;

  flow_community_id_hash dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_community_seed(cfg_community_seed),
    .start(start), .busy(busy),
    .in_is_ipv6(in_is_ipv6),
    .in_src_addr_hi(in_src_addr_hi), .in_src_addr_lo(in_src_addr_lo),
    .in_dst_addr_hi(in_dst_addr_hi), .in_dst_addr_lo(in_dst_addr_lo),
    .in_src_port(in_src_port), .in_dst_port(in_dst_port),
    .in_proto_num(in_proto_num),
    .out_strobe(out_strobe), .out_text_chunk(out_text_chunk),
    .out_chunk_bytes(out_chunk_bytes), .out_last(out_last)
  );

  always #5 clk = ~clk;

  function automatic logic [31:0] rol(logic [31:0] x, int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic logic [7:0] b64_of(logic [5:0] v);
    string alpha;
    alpha = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    return alpha[v];
  endfunction

  task automatic add_flow(flow_t f);
    pending_flows.insert(pending_flows.size(), f);
  endtask

  task automatic predict_identifier(flow_t f);
    logic [7:0]   sa[16], da[16], buf8[64], txt[30];
    logic [31:0]  w[80];
    logic [31:0]  h[5];
    logic [31:0]  a, b, c, d, e, fv, kv, t;
    logic [159:0] dig;
    logic [23:0]  g;
    logic         src_first;
    int           alen, pos, i, k;
    word_t        wd;
    h = '{32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0};
    alen = f.v6 ? 16 : 4;
    for (i = 0; i < 16; i++) begin
      sa[i] = 8'd0;
      da[i] = 8'd0;
    end
    for (i = 0; i < 8; i++) begin
      if (f.v6) begin
        sa[i] = f.sa_hi[63-8*i -: 8];
        sa[8+i] = f.sa_lo[63-8*i -: 8];
        da[i] = f.da_hi[63-8*i -: 8];
        da[8+i] = f.da_lo[63-8*i -: 8];
      end else if (i < 4) begin
        sa[i] = f.sa_lo[31-8*i -: 8];
        da[i] = f.da_lo[31-8*i -: 8];
      end
    end
    src_first = (f.sp < f.dp);
    for (i = alen - 1; i >= 0; i--) begin
      if (sa[i] != da[i]) src_first = (sa[i] < da[i]);
    end
    for (i = 0; i < 64; i++) buf8[i] = 8'd0;
    buf8[0] = seed_model[15:8];
    buf8[1] = seed_model[7:0];
    pos = 2;
    for (i = 0; i < alen; i++) buf8[pos+i] = src_first ? sa[i] : da[i];
    pos += alen;
    for (i = 0; i < alen; i++) buf8[pos+i] = src_first ? da[i] : sa[i];
    pos += alen;
    buf8[pos] = f.proto;
    buf8[pos+1] = 8'd0;
    buf8[pos+2] = src_first ? f.sp[15:8] : f.dp[15:8];
    buf8[pos+3] = src_first ? f.sp[7:0] : f.dp[7:0];
    buf8[pos+4] = src_first ? f.dp[15:8] : f.sp[15:8];
    buf8[pos+5] = src_first ? f.dp[7:0] : f.sp[7:0];
    pos += 6;
    buf8[pos] = 8'h80;
    buf8[62] = 8'((pos * 8) >> 8);
    buf8[63] = 8'((pos * 8) & 255);
    for (i = 0; i < 16; i++) w[i] = {buf8[4*i], buf8[4*i+1], buf8[4*i+2], buf8[4*i+3]};
    for (i = 16; i < 80; i++) w[i] = rol(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
    a = h[0]; b = h[1]; c = h[2]; d = h[3]; e = h[4];
    for (i = 0; i < 80; i++) begin
      if (i < 20) begin
        fv = (b & c) | (~b & d); kv = 32'h5A827999;
      end else if (i < 40) begin
        fv = b ^ c ^ d; kv = 32'h6ED9EBA1;
      end else if (i < 60) begin
        fv = (b & c) | (b & d) | (c & d); kv = 32'h8F1BBCDC;
      end else begin
        fv = b ^ c ^ d; kv = 32'hCA62C1D6;
      end
      t = rol(a, 5) + fv + e + kv + w[i];
      e = d; d = c; c = rol(b, 30); b = a; a = t;
    end
    dig = {h[0] + a, h[1] + b, h[2] + c, h[3] + d, h[4] + e};
    txt[0] = "1";
    txt[1] = ":";
    for (i = 0; i < 7; i++) begin
      g = (i < 6) ? dig[159-24*i -: 24] : {dig[15:0], 8'h00};
      txt[2+4*i] = b64_of(g[23:18]);
      txt[3+4*i] = b64_of(g[17:12]);
      txt[4+4*i] = b64_of(g[11:6]);
      txt[5+4*i] = (i < 6) ? b64_of(g[5:0]) : "=";
    end
    for (k = 0; k < 4; k++) begin
      wd.nbytes = (k == 3) ? 4'd6 : 4'd8;
      wd.last = (k == 3);
      wd.chunk = '0;
      for (i = 0; i < wd.nbytes; i++) wd.chunk[63-8*i -: 8] = txt[8*k+i];
      expected_words.insert(expected_words.size(), wd);
    end
  endtask

  function automatic flow_t random_flow();
    flow_t f;
    f.v6 = 1'($urandom_range(0, 1));
    f.sa_hi = {$urandom, $urandom};
    f.sa_lo = {$urandom, $urandom};
    f.da_hi = {$urandom, $urandom};
    f.da_lo = {$urandom, $urandom};
    f.sp = 16'($urandom);
    f.dp = 16'($urandom);
    f.proto = 8'($urandom);
    case ($urandom_range(0, 5))
      0: begin
        f.da_hi = f.sa_hi;
        f.da_lo = f.sa_lo;
      end
      1: begin
        f.da_hi = f.sa_hi;
        f.da_lo = f.sa_lo;
        f.dp = f.sp;
      end
      2: begin
        f.da_hi = f.sa_hi;
        f.da_lo = f.sa_lo ^ (64'd1 << $urandom_range(0, 63));
      end
      default: ;
    endcase
    return f;
  endfunction

  function automatic flow_t make_flow(logic v6, logic [63:0] sh, logic [63:0] sl,
                                      logic [63:0] dh, logic [63:0] dl,
                                      logic [15:0] sp, logic [15:0] dp, logic [7:0] pr);
    flow_t f;
    f.v6 = v6; f.sa_hi = sh; f.sa_lo = sl; f.da_hi = dh; f.da_lo = dl;
    f.sp = sp; f.dp = dp; f.proto = pr;
    return f;
  endfunction

  always @(negedge clk) begin
    if (rst_n && !cfg_we && (!start || !busy_q)) begin
      if (pending_flows.size() > 0 && $urandom_range(0, 99) >= gap_pct) begin
        flow_t f;
        f = pending_flows.pop_front();
        in_is_ipv6 <= f.v6;
        in_src_addr_hi <= f.sa_hi;
        in_src_addr_lo <= f.sa_lo;
        in_dst_addr_hi <= f.da_hi;
        in_dst_addr_lo <= f.da_lo;
        in_src_port <= f.sp;
        in_dst_port <= f.dp;
        in_proto_num <= f.proto;
        start <= 1'b1;
        predict_identifier(f);
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) busy_q <= busy;

  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (expected_words.size() == 0) begin
        $error("unexpected word %h", out_text_chunk);
        error_count++;
      end else begin
        word_t x;
        x = expected_words.pop_front();
        if (out_text_chunk !== x.chunk) begin
          $error("text_chunk expected %h actual %h", x.chunk, out_text_chunk);
          error_count++;
        end
        if (out_chunk_bytes !== x.nbytes) begin
          $error("chunk_bytes expected %0d actual %0d", x.nbytes, out_chunk_bytes);
          error_count++;
        end
        if (out_last !== x.last) begin
          $error("last expected %0d actual %0d", x.last, out_last);
          error_count++;
        end
      end
    end
  end

  task automatic drain();
    while (pending_flows.size() > 0 || start || expected_words.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_seed(logic [15:0] s);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_community_seed <= s;
    seed_model = s;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [63:0] ones;
    logic [63:0] zero;
    int ph, n;
    ones = '1;
    zero = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    add_flow(make_flow(1'b0, zero, zero, zero, zero, 16'd0, 16'd0, 8'd0));
    add_flow(make_flow(1'b0, ones, ones, ones, ones, 16'hFFFF, 16'hFFFF, 8'hFF));
    add_flow(make_flow(1'b1, zero, zero, zero, zero, 16'd0, 16'd0, 8'd0));
    add_flow(make_flow(1'b1, ones, ones, ones, ones, 16'hFFFF, 16'hFFFF, 8'hFF));
    add_flow(make_flow(1'b0, ones, 64'hC0A80001, zero, 64'h0A000001, 16'd80, 16'd1234,
                       8'd6));
    add_flow(make_flow(1'b0, zero, 64'h0A000001, ones, 64'hC0A80001, 16'd1234, 16'd80,
                       8'd17));
    add_flow(make_flow(1'b0, zero, 64'h0A000001, zero, 64'h0A000001, 16'd1, 16'd2, 8'd6));
    add_flow(make_flow(1'b0, zero, 64'h0A000001, zero, 64'h0A000001, 16'd2, 16'd1, 8'd6));
    add_flow(make_flow(1'b0, zero, 64'h0A000001, zero, 64'h0A000001, 16'd256, 16'd1,
                       8'd6));
    add_flow(make_flow(1'b1, 64'h20010DB8, 64'd5, 64'h20010DB8, 64'd5, 16'd53, 16'd53,
                       8'd17));
    add_flow(make_flow(1'b1, 64'd1, zero, zero, ones, 16'd9, 16'd9, 8'd58));
    add_flow(make_flow(1'b1, zero, ones, 64'd1, zero, 16'd9, 16'd9, 8'd58));
    add_flow(make_flow(1'b1, 64'd5, 64'd1, 64'd5, 64'd2, 16'd7, 16'd3, 8'd1));
    drain();
    write_seed(16'hFFFF);
    add_flow(make_flow(1'b0, zero, 64'h01020304, zero, 64'h05060708, 16'd1, 16'd2, 8'd6));
    add_flow(make_flow(1'b1, ones, zero, zero, ones, 16'd0, 16'hFFFF, 8'd0));
    drain();
    for (ph = 0; ph < 3; ph++) begin
      gap_pct = (ph == 0) ? 6 : (ph == 1) ? 84 : 0;
      write_seed((ph == 0) ? 16'd0 : (ph == 1) ? 16'(1) : 16'($urandom));
      n = (ph == 1) ? 80 : 160;
      repeat (n) add_flow(random_flow());
      drain();
    end
    if (error_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("testbench: errors");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/cidh_pkg.sv
rtl/cidh_prep.sv
rtl/cidh_cell.sv
rtl/cidh_out.sv
rtl/flow_community_id_hash.sv
rtl/cidh_checker.sv
bench/testbench.sv
